@@ src/alcd_pkg.sv @@
// Shared types and constants of the antialiased line engine.
package alcd_pkg;

    // Opcodes of an input beat
    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Divider operand widths: clip product magnitude and difference magnitude
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 17;

    // Clip rounds before a line is dropped
    localparam logic [3:0] CLIP_ROUNDS = 4'd8;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

endpackage

@@ src/alcd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module alcd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/alcd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module alcd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alcd_pkg::t_div_req i_req,
    output alcd_pkg::t_div_rsp o_rsp
);

    localparam int NW = alcd_pkg::DIV_NW;
    localparam int DW = alcd_pkg::DIV_DW;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW:0]   n_sh;
    logic          n_fit;

    // Shift in the next dividend bit and trial-subtract
    assign n_sh  = {r_rem, r_quo[NW-1]};
    assign n_fit = n_sh >= {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath; the partial remainder stays below the divisor
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_fit ? DW'(n_sh - {1'b0, r_den}) : DW'(n_sh);
            r_quo <= {r_quo[NW-2:0], n_fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;

endmodule

@@ src/antialiased_line_draw_with_clipping.sv @@
// Top level of the antialiased line engine with clipping and a pixel store.
// After reset the block sweeps the frame store to zero, one pixel a cycle,
// and takes no beat meanwhile; register writes are taken at any time. A pixel
// read passes through S_OP and S_RDPIX, a pixel write through S_OP alone. A
// draw takes one round (multiply plus a bit-serial divider) for each
// Cohen-Sutherland clip step, at most 8, then the endpoint writes and setup,
// then a solid run at one pixel per cycle, or a slope division and Wu steps,
// each with two read-modify-write passes through the single read port of the
// frame store. One item is in work at a time; the next beat is taken while a
// result still waits on the output.
module antialiased_line_draw_with_clipping #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_y_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_y_end,
    input  logic [7:0]         i_color_red,
    input  logic [7:0]         i_color_green,
    input  logic [7:0]         i_color_blue,
    // Result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_pixel_red,
    output logic [7:0]         o_pixel_green,
    output logic [7:0]         o_pixel_blue,
    output logic               o_line_drawn,
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = alcd_pkg::DIV_NW;
    localparam int DW    = alcd_pkg::DIV_DW;

    // Sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_OP    = 5'd2;
    localparam logic [4:0] S_RDPIX = 5'd3;
    localparam logic [4:0] S_CLIP  = 5'd4;
    localparam logic [4:0] S_MUL   = 5'd5;
    localparam logic [4:0] S_DIVGO = 5'd6;
    localparam logic [4:0] S_DIV   = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_E1    = 5'd9;
    localparam logic [4:0] S_E2    = 5'd10;
    localparam logic [4:0] S_SETUP = 5'd11;
    localparam logic [4:0] S_CLASS = 5'd12;
    localparam logic [4:0] S_RUN   = 5'd13;
    localparam logic [4:0] S_WUGO  = 5'd14;
    localparam logic [4:0] S_WUDIV = 5'd15;
    localparam logic [4:0] S_STEP  = 5'd16;
    localparam logic [4:0] S_RDA   = 5'd17;
    localparam logic [4:0] S_WRA   = 5'd18;
    localparam logic [4:0] S_RDB   = 5'd19;
    localparam logic [4:0] S_WRB   = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;

    // ---- helpers ----
    function automatic logic signed [16:0] f_sub(logic signed [15:0] a,
                                                 logic signed [15:0] b);
        return {a[15], a} - {b[15], b};
    endfunction

    function automatic logic f_in_win(logic signed [15:0] x, logic signed [15:0] y,
                                      logic [15:0] wx, logic [15:0] wy);
        return !x[15] && !y[15] && ($unsigned(x) <= wx) && ($unsigned(y) <= wy);
    endfunction

    function automatic logic [3:0] f_outcode(logic signed [15:0] x,
                                             logic signed [15:0] y,
                                             logic [15:0] wx, logic [15:0] wy);
        logic [3:0] k;
        k    = '0;
        k[0] = y[15];
        k[1] = !y[15] && ($unsigned(y) > wy);
        k[2] = x[15];
        k[3] = !x[15] && ($unsigned(x) > wx);
        return k;
    endfunction

    // back + floor(w * (col - back) / 256), low byte
    function automatic logic [7:0] f_blend8(logic [7:0] back, logic [7:0] col,
                                            logic [7:0] w);
        logic signed [8:0]  d;
        logic signed [17:0] p;
        d = $signed({1'b0, col}) - $signed({1'b0, back});
        p = $signed({1'b0, w}) * d;
        return back + p[15:8];
    endfunction

    function automatic logic [23:0] f_blend(logic [23:0] back, logic [23:0] col,
                                            logic [7:0] w);
        return {f_blend8(back[23:16], col[23:16], w),
                f_blend8(back[15:8], col[15:8], w),
                f_blend8(back[7:0], col[7:0], w)};
    endfunction

    // ---- registers ----
    logic [4:0]         r_state;
    logic [7:0]         r_clip_x, r_clip_y;
    logic [AW-1:0]      r_clr;
    logic [1:0]         r_op;
    logic signed [15:0] r_x1, r_y1, r_x2, r_y2;
    logic [23:0]        r_col;
    logic [23:0]        r_res_pix;
    logic               r_res_drawn;
    logic [3:0]         r_round;
    logic               r_sel, r_xedge, r_sign;
    logic signed [15:0] r_base, r_edge;
    logic signed [16:0] r_num1, r_num2, r_den;
    logic signed [33:0] r_prod;
    logic [15:0]        r_len, r_cnt, r_acc, r_adj, r_dmin;
    logic               r_xneg, r_step_x, r_step_y, r_steep;
    logic [7:0]         r_w;
    logic [AW-1:0]      r_addr;
    logic               r_out_valid;
    logic [23:0]        r_out_pix;
    logic               r_out_drawn;

    // ---- window ----
    logic [15:0] w_win_x, w_win_y;
    assign w_win_x = ({8'd0, r_clip_x} > 16'(FRAME_WIDTH - 1))
                   ? 16'(FRAME_WIDTH - 1) : {8'd0, r_clip_x};
    assign w_win_y = ({8'd0, r_clip_y} > 16'(FRAME_HEIGHT - 1))
                   ? 16'(FRAME_HEIGHT - 1) : {8'd0, r_clip_y};

    // ---- register port ----
    assign pready = 1'b1;
    assign prdata = {24'd0, paddr[2] ? r_clip_y : r_clip_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_x <= 8'hFF;
            r_clip_y <= 8'hFF;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_clip_y <= pwdata[7:0];
            end else begin
                r_clip_x <= pwdata[7:0];
            end
        end
    end

    // ---- clip round decode ----
    logic [3:0]         w_k1, w_k2, w_k;
    logic signed [15:0] w_px, w_py, w_qx, w_qy, w_ex, w_ey;
    logic               w_xe, w_fail;

    assign w_k1  = f_outcode(r_x1, r_y1, w_win_x, w_win_y);
    assign w_k2  = f_outcode(r_x2, r_y2, w_win_x, w_win_y);
    assign w_k   = (w_k1 != 4'd0) ? w_k1 : w_k2;
    assign w_px  = (w_k1 != 4'd0) ? r_x1 : r_x2;
    assign w_py  = (w_k1 != 4'd0) ? r_y1 : r_y2;
    assign w_qx  = (w_k1 != 4'd0) ? r_x2 : r_x1;
    assign w_qy  = (w_k1 != 4'd0) ? r_y2 : r_y1;
    assign w_xe  = |w_k[3:2];
    assign w_ex  = w_k[2] ? 16'sd0 : $signed(w_win_x);
    assign w_ey  = w_k[0] ? 16'sd0 : $signed(w_win_y);
    assign w_fail = (|w_k[1:0] && (w_py == w_qy)) || (w_xe && (w_px == w_qx));

    // ---- divider ----
    alcd_pkg::t_div_req w_div_req;
    alcd_pkg::t_div_rsp w_div_rsp;
    logic signed [33:0] w_prod_abs;
    logic signed [16:0] w_den_abs;

    assign w_prod_abs = r_prod[33] ? -r_prod : r_prod;
    assign w_den_abs  = r_den[16] ? -r_den : r_den;

    always_comb begin
        w_div_req.start = (r_state == S_DIVGO) || (r_state == S_WUGO);
        if (r_state == S_WUGO) begin
            w_div_req.num = NW'({r_dmin, 16'd0});
            w_div_req.den = DW'(r_len);
        end else begin
            w_div_req.num = $unsigned(w_prod_abs);
            w_div_req.den = $unsigned(w_den_abs);
        end
    end

    alcd_div u_alcd_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // Clipped coordinate from the quotient
    logic signed [17:0] w_q18, w_newv18;
    logic signed [15:0] w_newv;
    assign w_q18    = r_sign ? -$signed(w_div_rsp.quo[17:0]) : $signed(w_div_rsp.quo[17:0]);
    assign w_newv18 = {{2{r_base[15]}}, r_base} + w_q18;
    assign w_newv   = w_newv18[15:0];

    // ---- Wu step values ----
    logic [15:0]        w_acc_n;
    logic               w_carry;
    logic signed [15:0] w_xs;
    assign w_acc_n = r_acc + r_adj;
    assign w_carry = w_acc_n <= r_acc;
    assign w_xs    = r_xneg ? -16'sd1 : 16'sd1;

    // ---- setup values ----
    logic signed [16:0] w_dxs, w_dys;
    logic [15:0]        w_dxm, w_dym;
    assign w_dxs = f_sub(r_x2, r_x1);
    assign w_dys = f_sub(r_y2, r_y1);
    assign w_dxm = w_dxs[16] ? 16'(-w_dxs) : w_dxs[15:0];
    assign w_dym = w_dys[15:0];

    // ---- pixel address ----
    logic signed [15:0] w_pt_x, w_pt_y;
    logic [31:0]        w_lin;
    logic [AW-1:0]      w_pt_addr;
    logic               w_pt_win, w_pt_hit;

    always_comb begin
        w_pt_x = r_x1;
        w_pt_y = r_y1;
        if (r_state == S_E2) begin
            w_pt_x = r_x2;
            w_pt_y = r_y2;
        end else if (r_state == S_RDA) begin
            if (r_steep) begin
                w_pt_x = r_x1 + w_xs;
            end else begin
                w_pt_y = r_y1 + 16'sd1;
            end
        end
    end

    assign w_lin     = 32'($unsigned(w_pt_y)) * 32'(FRAME_WIDTH) + 32'($unsigned(w_pt_x));
    assign w_pt_addr = w_lin[AW-1:0];
    assign w_pt_win  = f_in_win(w_pt_x, w_pt_y, w_win_x, w_win_y);
    assign w_pt_hit  = !w_pt_x[15] && !w_pt_y[15]
                    && ($unsigned(w_pt_x) < 16'(FRAME_WIDTH))
                    && ($unsigned(w_pt_y) < 16'(FRAME_HEIGHT));

    // ---- frame store ----
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr;
    logic [23:0]   w_wdata, w_rdata;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_pt_addr;
        w_wdata = r_col;
        w_re    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_OP: begin
                w_we = (r_op == alcd_pkg::OP_WRITE) && w_pt_hit;
                w_re = (r_op == alcd_pkg::OP_READ) && w_pt_hit;
            end
            S_E1, S_E2, S_RUN: begin
                w_we = w_pt_win;
            end
            S_RDA, S_RDB: begin
                w_re = w_pt_win;
            end
            S_WRA: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = f_blend(w_rdata, r_col, r_w);
            end
            S_WRB: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = f_blend(w_rdata, r_col, ~r_w);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    alcd_ram #(
        .WIDTH(24),
        .DEPTH(DEPTH)
    ) u_alcd_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_pt_addr),
        .o_rdata(w_rdata)
    );

    // ---- handshakes ----
    logic w_out_load;
    assign o_ready    = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_OP;
                    end
                end
                S_OP: begin
                    if (r_op == alcd_pkg::OP_DRAW
                        && !(r_x1 == r_x2 && r_y1 == r_y2)) begin
                        r_state <= S_CLIP;
                    end else if (r_op == alcd_pkg::OP_READ && w_pt_hit) begin
                        r_state <= S_RDPIX;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RDPIX: r_state <= S_DONE;
                S_CLIP: begin
                    if (r_round == alcd_pkg::CLIP_ROUNDS || (w_k1 & w_k2) != 4'd0) begin
                        r_state <= S_DONE;
                    end else if ((w_k1 | w_k2) == 4'd0) begin
                        r_state <= S_CHK;
                    end else if (w_fail) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:   r_state <= S_DIVGO;
                S_DIVGO: r_state <= S_DIV;
                S_DIV: begin
                    if (!w_div_rsp.busy) begin
                        r_state <= S_CLIP;
                    end
                end
                S_CHK: begin
                    r_state <= (r_x1 == r_x2 && r_y1 == r_y2) ? S_DONE : S_E1;
                end
                S_E1:    r_state <= S_E2;
                S_E2:    r_state <= S_SETUP;
                S_SETUP: r_state <= S_CLASS;
                S_CLASS: begin
                    if (w_dym == 16'd0 || w_dxm == 16'd0 || w_dxm == w_dym) begin
                        r_state <= S_RUN;
                    end else begin
                        r_state <= S_WUGO;
                    end
                end
                S_RUN: begin
                    if (r_cnt + 16'd1 >= r_len) begin
                        r_state <= S_DONE;
                    end
                end
                S_WUGO: r_state <= S_WUDIV;
                S_WUDIV: begin
                    if (!w_div_rsp.busy) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP:  r_state <= (r_cnt >= r_len) ? S_DONE : S_RDA;
                S_RDA:   r_state <= w_pt_win ? S_WRA : S_RDB;
                S_WRA:   r_state <= S_RDB;
                S_RDB:   r_state <= w_pt_win ? S_WRB : S_STEP;
                S_WRB:   r_state <= S_STEP;
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op        <= i_opcode;
                r_x1        <= i_x_start;
                r_y1        <= i_y_start;
                r_x2        <= i_x_end;
                r_y2        <= i_y_end;
                r_col       <= {i_color_blue, i_color_green, i_color_red};
                r_res_pix   <= '0;
                r_res_drawn <= 1'b0;
                r_round     <= '0;
            end
            S_RDPIX: r_res_pix <= w_rdata;
            S_CLIP: begin
                // latch one clip step: new coord = base + num1*num2/den
                r_sel   <= (w_k1 == 4'd0);
                r_xedge <= w_xe;
                if (w_xe) begin
                    r_num1 <= f_sub(w_py, w_qy);
                    r_num2 <= f_sub(w_ex, w_qx);
                    r_den  <= f_sub(w_px, w_qx);
                    r_base <= w_qy;
                    r_edge <= w_ex;
                end else begin
                    r_num1 <= f_sub(w_px, w_qx);
                    r_num2 <= f_sub(w_ey, w_qy);
                    r_den  <= f_sub(w_py, w_qy);
                    r_base <= w_qx;
                    r_edge <= w_ey;
                end
            end
            S_MUL: r_prod <= r_num1 * r_num2;
            S_DIVGO: r_sign <= r_prod[33] ^ r_den[16];
            S_DIV: begin
                if (!w_div_rsp.busy) begin
                    r_round <= r_round + 4'd1;
                    if (r_sel) begin
                        r_x2 <= r_xedge ? r_edge : w_newv;
                        r_y2 <= r_xedge ? w_newv : r_edge;
                    end else begin
                        r_x1 <= r_xedge ? r_edge : w_newv;
                        r_y1 <= r_xedge ? w_newv : r_edge;
                    end
                end
            end
            S_SETUP: begin
                // walk from the upper endpoint
                if (r_y1 > r_y2) begin
                    r_x1 <= r_x2;
                    r_y1 <= r_y2;
                    r_x2 <= r_x1;
                    r_y2 <= r_y1;
                end
            end
            S_CLASS: begin
                r_xneg      <= w_dxs[16];
                r_cnt       <= '0;
                r_res_drawn <= 1'b1;
                r_steep     <= w_dym > w_dxm;
                if (w_dym == 16'd0) begin
                    r_len    <= w_dxm;
                    r_step_x <= 1'b1;
                    r_step_y <= 1'b0;
                end else if (w_dxm == 16'd0) begin
                    r_len    <= w_dym;
                    r_step_x <= 1'b0;
                    r_step_y <= 1'b1;
                end else if (w_dxm == w_dym) begin
                    r_len    <= w_dym;
                    r_step_x <= 1'b1;
                    r_step_y <= 1'b1;
                end else begin
                    r_len  <= (w_dym > w_dxm) ? w_dym : w_dxm;
                    r_dmin <= (w_dym > w_dxm) ? w_dxm : w_dym;
                end
            end
            S_RUN: begin
                r_cnt <= r_cnt + 16'd1;
                if (r_step_x) begin
                    r_x1 <= r_x1 + w_xs;
                end
                if (r_step_y) begin
                    r_y1 <= r_y1 + 16'sd1;
                end
            end
            S_WUDIV: begin
                r_adj <= w_div_rsp.quo[15:0];
                r_acc <= '0;
                r_cnt <= 16'd1;
            end
            S_STEP: begin
                if (r_cnt < r_len) begin
                    r_acc <= w_acc_n;
                    r_w   <= w_acc_n[15:8];
                    r_cnt <= r_cnt + 16'd1;
                    if (r_steep) begin
                        r_y1 <= r_y1 + 16'sd1;
                        if (w_carry) begin
                            r_x1 <= r_x1 + w_xs;
                        end
                    end else begin
                        r_x1 <= r_x1 + w_xs;
                        if (w_carry) begin
                            r_y1 <= r_y1 + 16'sd1;
                        end
                    end
                end
            end
            S_RDA, S_RDB: r_addr <= w_pt_addr;
            default: begin
                r_addr <= r_addr;
            end
        endcase
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pix   <= r_res_pix;
            r_out_drawn <= r_res_drawn;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_red   = r_out_pix[7:0];
    assign o_pixel_green = r_out_pix[15:8];
    assign o_pixel_blue  = r_out_pix[23:16];
    assign o_line_drawn  = r_out_drawn;

endmodule

@@ src/alcd_checker.sv @@
// Port-level checks of the line engine, bound to the top level.
module alcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pixel_red,
    input logic [7:0] o_pixel_green,
    input logic [7:0] o_pixel_blue,
    input logic       o_line_drawn
);

    // A stalled result beat holds its valid, line flag and red channel
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_line_drawn)
                                && $stable(o_pixel_red))
        else $error("result beat changed while stalled");

    // A drawn line never carries pixel colour
    a_drawn_no_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_drawn |-> o_pixel_red == 8'd0 && o_pixel_green == 8'd0
                                    && o_pixel_blue == 8'd0)
        else $error("line result with pixel colour");

    // One command in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second command taken back to back");

endmodule

bind antialiased_line_draw_with_clipping alcd_checker u_alcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pixel_red  (o_pixel_red),
    .o_pixel_green(o_pixel_green),
    .o_pixel_blue (o_pixel_blue),
    .o_line_drawn (o_line_drawn)
);

@@ dv/tb_antialiased_line_draw_with_clipping.sv @@
// Testbench of the antialiased line engine: random and directed commands against a model.
module tb_antialiased_line_draw_with_clipping;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = 256;
    localparam int FH = 256;
    localparam logic [2:0] ADDR_MAX_X = 3'd0;
    localparam logic [2:0] ADDR_MAX_Y = 3'd4;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       drawn;
    } t_pixel_result;

    // Line engine model and queue of expected result beats
    class line_scoreboard;
        logic [23:0] frame [FW*FH];
        int unsigned win_x, win_y;
        t_pixel_result pending [$];
        int errors;

        function new();
            foreach (frame[i]) frame[i] = '0;
            win_x = 255;
            win_y = 255;
            errors = 0;
        endfunction

        function void set_max_x(logic [7:0] v);
            win_x = (v < FW - 1) ? v : FW - 1;
        endfunction

        function void set_max_y(logic [7:0] v);
            win_y = (v < FH - 1) ? v : FH - 1;
        endfunction

        function bit visible(longint x, longint y);
            return x >= 0 && y >= 0 && x <= win_x && y <= win_y;
        endfunction

        function void paint(longint x, longint y, logic [23:0] c);
            if (visible(x, y)) frame[y*FW + x] = c;
        endfunction

        function logic [7:0] mix(logic [7:0] back, logic [7:0] col, int w);
            int p, q;
            p = w * (int'(col) - int'(back));
            q = (p >= 0) ? p / 256 : -((-p + 255) / 256);
            return 8'(int'(back) + q);
        endfunction

        function void shade(longint x, longint y, logic [23:0] c, int w);
            logic [23:0] b;
            if (!visible(x, y)) return;
            b = frame[y*FW + x];
            frame[y*FW + x] = {mix(b[23:16], c[23:16], w), mix(b[15:8], c[15:8], w),
                               mix(b[7:0], c[7:0], w)};
        endfunction

        function int region(longint x, longint y);
            int k;
            k = 0;
            if (y < 0) k |= 1; else if (y > win_y) k |= 2;
            if (x < 0) k |= 4; else if (x > win_x) k |= 8;
            return k;
        endfunction

        // Moves (px,py) onto the window edge toward (qx,qy)
        function bit snap(int k, inout longint px, inout longint py, input longint qx,
                          input longint qy);
            longint x, y, e;
            x = px;
            y = py;
            if (k & 3) begin
                e = (k & 1) ? 0 : win_y;
                if (py == qy) return 0;
                x = qx + ((px - qx) * (e - qy)) / (py - qy);
                y = e;
            end
            if (k & 12) begin
                e = (k & 4) ? 0 : win_x;
                if (px == qx) return 0;
                y = qy + ((py - qy) * (e - qx)) / (px - qx);
                x = e;
            end
            px = x;
            py = y;
            return 1;
        endfunction

        function bit draw(longint x1, longint y1, longint x2, longint y2, logic [23:0] c);
            bit ok;
            int k1, k2;
            longint dx, dy, xs, t;
            int unsigned adj, acc, prev, w;
            ok = 0;
            if (x1 == x2 && y1 == y2) return 0;
            for (int r = 0; r < 8; r++) begin
                k1 = region(x1, y1);
                k2 = region(x2, y2);
                if (k1 & k2) return 0;
                if ((k1 | k2) == 0) begin
                    ok = 1;
                    break;
                end
                if (k1 != 0) begin
                    if (!snap(k1, x1, y1, x2, y2)) return 0;
                end else begin
                    if (!snap(k2, x2, y2, x1, y1)) return 0;
                end
            end
            if (!ok) return 0;
            if (x1 == x2 && y1 == y2) return 0;
            paint(x1, y1, c);
            paint(x2, y2, c);
            if (y1 > y2) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            dx = x2 - x1;
            xs = 1;
            if (dx < 0) begin
                xs = -1;
                dx = -dx;
            end
            dy = y2 - y1;
            if (dy == 0) begin
                for (t = 0; t < dx; t++) paint(x1 + t*xs, y1, c);
                return 1;
            end
            if (dx == 0) begin
                for (t = 0; t < dy; t++) paint(x1, y1 + t, c);
                return 1;
            end
            if (dx == dy) begin
                for (t = 0; t < dy; t++) paint(x1 + t*xs, y1 + t, c);
                return 1;
            end
            acc = 0;
            // Wu stepping along the major axis
            if (dy > dx) begin
                adj = ((dx << 16) / dy) & 16'hFFFF;
                for (t = 1; t < dy; t++) begin
                    prev = acc;
                    acc = (acc + adj) & 16'hFFFF;
                    if (acc <= prev) x1 += xs;
                    y1++;
                    w = acc >> 8;
                    shade(x1 + xs, y1, c, w);
                    shade(x1, y1, c, w ^ 255);
                end
                return 1;
            end
            adj = ((dy << 16) / dx) & 16'hFFFF;
            for (t = 1; t < dx; t++) begin
                prev = acc;
                acc = (acc + adj) & 16'hFFFF;
                if (acc <= prev) y1++;
                x1 += xs;
                w = acc >> 8;
                shade(x1, y1 + 1, c, w);
                shade(x1, y1, c, w ^ 255);
            end
            return 1;
        endfunction

        function void note_command(logic [1:0] op, logic signed [15:0] xa,
                                   logic signed [15:0] ya, logic signed [15:0] xb,
                                   logic signed [15:0] yb, logic [23:0] c);
            t_pixel_result r;
            bit hit;
            logic [23:0] p;
            r = '0;
            hit = xa >= 0 && ya >= 0 && xa < FW && ya < FH;
            if (op == alcd_pkg::OP_DRAW) r.drawn = draw(xa, ya, xb, yb, c);
            else if (op == alcd_pkg::OP_READ && hit) begin
                p = frame[ya*FW + xa];
                r.red = p[7:0];
                r.green = p[15:8];
                r.blue = p[23:16];
            end else if (op == alcd_pkg::OP_WRITE && hit) frame[ya*FW + xa] = c;
            pending.push_back(r);
        endfunction

        function void check_result(t_pixel_result got);
            t_pixel_result e;
            if (pending.size() == 0) begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.red !== e.red) begin
                $error("pixel_red exp %0d got %0d", e.red, got.red);
                errors++;
            end
            if (got.green !== e.green) begin
                $error("pixel_green exp %0d got %0d", e.green, got.green);
                errors++;
            end
            if (got.blue !== e.blue) begin
                $error("pixel_blue exp %0d got %0d", e.blue, got.blue);
                errors++;
            end
            if (got.drawn !== e.drawn) begin
                $error("line_drawn exp %0d got %0d", e.drawn, got.drawn);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, o_ready, o_valid, i_ready = 0;
    logic [1:0] i_opcode = '0;
    logic signed [15:0] i_x_start = '0, i_y_start = '0, i_x_end = '0, i_y_end = '0;
    logic [7:0] i_color_red = '0, i_color_green = '0, i_color_blue = '0;
    logic [7:0] o_pixel_red, o_pixel_green, o_pixel_blue;
    logic o_line_drawn;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;

    line_scoreboard sb;
    int stall_mode;

    antialiased_line_draw_with_clipping uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Result side: stall pattern switches between none, sparse and heavy
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_pixel_red, o_pixel_green, o_pixel_blue, o_line_drawn});
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Setup phase and access phase, then the bus goes idle
    task automatic reg_write(logic [2:0] a, logic [7:0] v);
        psel <= 1; pwrite <= 1; paddr <= a; pwdata <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
        if (a == ADDR_MAX_X) sb.set_max_x(v);
        else sb.set_max_y(v);
    endtask

    task automatic send(logic [1:0] op, int xa, int ya, int xb, int yb, logic [23:0] c);
        i_valid <= 1; i_opcode <= op;
        i_x_start <= 16'(xa); i_y_start <= 16'(ya); i_x_end <= 16'(xb); i_y_end <= 16'(yb);
        i_color_red <= c[7:0]; i_color_green <= c[15:8]; i_color_blue <= c[23:16];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_command(op, 16'(xa), 16'(ya), 16'(xb), 16'(yb), c);
    endtask

    task automatic gap();
        i_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    function automatic int coord();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            2, 3: return $urandom_range(0, 400) - 100;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Random phase: short lines mostly, with pixel reads, writes and the spare opcode mixed in
    task automatic random_phase(int n);
        int burst, xa, ya, len;
        logic [1:0] op;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                gap();
                burst = $urandom_range(1, 12);
            end
            burst--;
            op = 2'($urandom_range(0, 9) < 5 ? alcd_pkg::OP_DRAW : $urandom_range(1, 3));
            xa = coord();
            ya = coord();
            len = ($urandom_range(0, 15) == 0) ? 300 : 24;
            if ($urandom_range(0, 3) == 0)
                send(op, xa, ya, coord(), coord(), 24'($urandom));
            else
                send(op, xa, ya, xa + $urandom_range(0, 2*len) - len,
                     ya + $urandom_range(0, 2*len) - len, 24'($urandom));
        end
    endtask

    initial begin
        sb = new();
        stall_mode = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        // Directed: extremes, each opcode, every drawing path
        send(alcd_pkg::OP_WRITE, 0, 0, 0, 0, 24'hFFFFFF);
        send(alcd_pkg::OP_READ, 0, 0, 0, 0, 0);
        send(alcd_pkg::OP_WRITE, 255, 255, 0, 0, 24'h123456);
        send(alcd_pkg::OP_READ, 255, 255, 0, 0, 0);
        send(alcd_pkg::OP_WRITE, -1, 300, 0, 0, 24'hABCDEF);
        send(alcd_pkg::OP_READ, -32768, 32767, 0, 0, 0);
        send(OP_SPARE, 5, 5, 9, 9, 24'hFFFFFF);
        send(alcd_pkg::OP_DRAW, 10, 10, 10, 10, 24'h00FF00);
        send(alcd_pkg::OP_DRAW, 0, 20, 255, 20, 24'hFF0000);
        send(alcd_pkg::OP_DRAW, 30, 0, 30, 255, 24'h0000FF);
        send(alcd_pkg::OP_DRAW, 40, 40, 90, 90, 24'h808080);
        send(alcd_pkg::OP_DRAW, 90, 40, 40, 90, 24'h808080);
        send(alcd_pkg::OP_DRAW, 5, 100, 200, 137, 24'hFFFFFF);
        send(alcd_pkg::OP_DRAW, 100, 5, 137, 200, 24'hFFFFFF);
        send(alcd_pkg::OP_READ, 50, 107, 0, 0, 0);
        send(alcd_pkg::OP_DRAW, -32768, -32768, 32767, 32767, 24'h0F0F0F);
        send(alcd_pkg::OP_DRAW, -100, 50, 400, 70, 24'h00FFFF);
        send(alcd_pkg::OP_DRAW, -10, -10, -5, -20, 24'hFFFFFF);
        send(alcd_pkg::OP_DRAW, -5, 0, 0, -5, 24'hFFFFFF);
        send(alcd_pkg::OP_DRAW, 32767, -32768, -32768, 32767, 24'h55AA55);
        drain();
        // Several window settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            stall_mode = ph % 3;
            case (ph)
                0: begin reg_write(ADDR_MAX_X, 8'd0); reg_write(ADDR_MAX_Y, 8'd0); end
                1: begin reg_write(ADDR_MAX_X, 8'd255); reg_write(ADDR_MAX_Y, 8'd255); end
                default: begin
                    reg_write(ADDR_MAX_X, 8'($urandom_range(0, 255)));
                    reg_write(ADDR_MAX_Y, 8'($urandom_range(0, 255)));
                end
            endcase
            random_phase(ph == 0 ? 80 : 210);
            drain();
        end
        if (sb.errors == 0) $display("tb_antialiased_line_draw_with_clipping passed");
        else $display("tb_antialiased_line_draw_with_clipping failed");
        $finish;
    end

    initial begin
        #300ms;
        $display("tb_antialiased_line_draw_with_clipping failed");
        $finish;
    end
endmodule
